[hw/rtl/sgoa_pkg.sv]
`default_nettype none

package sgoa_pkg;

    localparam int DEF_MAX_REF_LEN   = 1024;
    localparam int DEF_MAX_QUERY_LEN = 4096;

    localparam int SYM_W       = 8;
    localparam int PFX_W       = 13;
    localparam int SCORE_OUT_W = 14;

    localparam logic OP_REF = 1'b0;
    localparam logic OP_QRY = 1'b1;

    // control that travels with one query row along the chain
    typedef struct packed {
        logic             vld;
        logic             lst;
        logic [SYM_W-1:0] sym;
    } t_wave;

endpackage

`default_nettype wire

[hw/rtl/sgoa_cell.sv]
`default_nettype none

module sgoa_cell #(
    parameter int SCORE_W = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_clr,
    input  wire logic                              i_load,
    input  wire logic [sgoa_pkg::SYM_W-1:0]        i_load_sym,
    input  wire logic                              i_prev_act,
    output logic                                   o_act,
    input  wire sgoa_pkg::t_wave                   i_wave,
    input  wire logic signed [SCORE_W-1:0]         i_new,
    input  wire logic signed [SCORE_W-1:0]         i_old,
    output sgoa_pkg::t_wave                        o_wave,
    output logic signed [SCORE_W-1:0]              o_new,
    output logic signed [SCORE_W-1:0]              o_old
);
    import sgoa_pkg::*;

    localparam logic signed [SCORE_W-1:0] ONE = SCORE_W'(1);

    logic                      r_act;
    logic [SYM_W-1:0]          r_ref;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [SCORE_W-1:0] r_new;
    logic signed [SCORE_W-1:0] r_old;
    t_wave                     r_wave;

    logic signed [SCORE_W-1:0] w_up_m;
    logic signed [SCORE_W-1:0] w_left_m;
    logic signed [SCORE_W-1:0] w_diag_m;
    logic signed [SCORE_W-1:0] w_diag_p;
    logic signed [SCORE_W-1:0] w_gap;
    logic signed [SCORE_W-1:0] n_score;

    always_comb begin
        w_up_m   = r_score - ONE;
        w_left_m = i_new - ONE;
        w_diag_m = i_old - ONE;
        w_diag_p = i_old + ONE;
        w_gap    = (w_up_m > w_left_m) ? w_up_m : w_left_m;
        n_score  = (w_gap > w_diag_m) ? w_gap : w_diag_m;
        if (r_ref == i_wave.sym && w_diag_p > n_score) begin
            n_score = w_diag_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_act   <= 1'b0;
            r_score <= '0;
            r_wave  <= '0;
        end else begin
            r_wave <= i_wave;
            // the first empty cell after the filled ones takes the next reference symbol
            if (i_load && i_prev_act && !r_act) begin
                r_act <= 1'b1;
            end
            if (i_wave.vld && r_act) begin
                r_score <= n_score;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_prev_act && !r_act) begin
            r_ref <= i_load_sym;
        end
        // past the reference end, pass the row end score straight through
        r_new <= r_act ? n_score : i_new;
        r_old <= r_score;
    end

    assign o_act  = r_act;
    assign o_wave = r_wave;
    assign o_new  = r_new;
    assign o_old  = r_old;

endmodule

`default_nettype wire

[hw/rtl/sgoa_ctrl.sv]
`default_nettype none

module sgoa_ctrl #(
    parameter int MAX_REF_LEN   = 1024,
    parameter int MAX_QUERY_LEN = 4096,
    parameter int SCORE_W       = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_opcode,
    input  wire logic [sgoa_pkg::SYM_W-1:0]             i_symbol,
    input  wire logic                                   i_is_last,
    output logic                                        o_load,
    output logic [sgoa_pkg::SYM_W-1:0]                  o_load_sym,
    output logic                                        o_clr,
    output sgoa_pkg::t_wave                             o_feed,
    output logic signed [SCORE_W-1:0]                   o_feed_new,
    output logic signed [SCORE_W-1:0]                   o_feed_old,
    input  wire sgoa_pkg::t_wave                        i_exit,
    input  wire logic signed [SCORE_W-1:0]              i_exit_new,
    output logic                                        o_valid,
    output logic [sgoa_pkg::PFX_W-1:0]                  o_best_prefix_len,
    output logic signed [sgoa_pkg::SCORE_OUT_W-1:0]     o_best_score,
    output logic                                        o_length_overflow
);
    import sgoa_pkg::*;

    localparam int RLW = $clog2(MAX_REF_LEN + 1);
    localparam int QW  = $clog2(MAX_QUERY_LEN + 1);

    logic [RLW-1:0]             r_ref_len;
    logic [QW-1:0]              r_qidx;
    logic [QW-1:0]              r_out_row;
    logic [QW-1:0]              r_best_pfx;
    logic signed [SCORE_W-1:0]  r_best_val;
    logic                       r_ovf;
    logic                       r_busy;
    t_wave                      r_feed;
    logic signed [SCORE_W-1:0]  r_feed_new;
    logic signed [SCORE_W-1:0]  r_feed_old;
    logic                       r_valid;
    logic [PFX_W-1:0]           r_res_pfx;
    logic signed [SCORE_OUT_W-1:0] r_res_score;
    logic                       r_res_ovf;

    logic                       w_acc;
    logic                       w_ref_acc;
    logic                       w_ref_full;
    logic                       w_q_acc;
    logic                       w_q_full;
    logic                       w_q_score;
    logic [QW-1:0]              w_row;
    logic [QW-1:0]              w_out_row;
    logic signed [SCORE_W-1:0]  w_half;
    logic                       w_take;
    logic [QW-1:0]              n_best_pfx;
    logic signed [SCORE_W-1:0]  n_best_val;

    always_comb begin
        w_acc      = start && !r_busy;
        w_ref_acc  = w_acc && (i_opcode == OP_REF) && (r_qidx == '0);
        w_ref_full = r_ref_len >= RLW'(MAX_REF_LEN);
        w_q_acc    = w_acc && (i_opcode == OP_QRY);
        w_q_full   = r_qidx >= QW'(MAX_QUERY_LEN);
        w_q_score  = w_q_acc && !w_q_full;
        w_row      = r_qidx + QW'(1);

        w_out_row  = r_out_row + QW'(1);
        w_half     = $signed(SCORE_W'(w_out_row >> 1));
        w_take     = i_exit.vld && (i_exit_new >= w_half) && (r_best_val < i_exit_new);
        n_best_val = w_take ? i_exit_new : r_best_val;
        n_best_pfx = w_take ? w_out_row : r_best_pfx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len  <= '0;
            r_qidx     <= '0;
            r_out_row  <= '0;
            r_best_pfx <= '0;
            r_best_val <= '0;
            r_ovf      <= 1'b0;
            r_busy     <= 1'b0;
            r_feed     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid    <= i_exit.lst;
            r_feed.vld <= w_q_score;
            r_feed.lst <= w_q_acc && i_is_last;
            r_feed.sym <= i_symbol;

            if (i_exit.lst) begin
                r_ref_len  <= '0;
                r_qidx     <= '0;
                r_out_row  <= '0;
                r_best_pfx <= '0;
                r_best_val <= '0;
                r_ovf      <= 1'b0;
                r_busy     <= 1'b0;
            end else begin
                if (o_load) begin
                    r_ref_len <= r_ref_len + RLW'(1);
                end
                if ((w_ref_acc && w_ref_full) || (w_q_acc && w_q_full)) begin
                    r_ovf <= 1'b1;
                end
                if (w_q_score) begin
                    r_qidx <= w_row;
                end
                // hold off requests until the final row leaves the chain
                if (w_q_acc && i_is_last) begin
                    r_busy <= 1'b1;
                end
                if (i_exit.vld) begin
                    r_out_row  <= w_out_row;
                    r_best_val <= n_best_val;
                    r_best_pfx <= n_best_pfx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_feed_new <= SCORE_W'(0) - $signed(SCORE_W'(w_row));
        r_feed_old <= SCORE_W'(0) - $signed(SCORE_W'(r_qidx));
        if (i_exit.lst) begin
            r_res_pfx   <= PFX_W'(n_best_pfx);
            r_res_score <= SCORE_OUT_W'(n_best_val);
            r_res_ovf   <= r_ovf;
        end
    end

    assign busy              = r_busy;
    assign o_load            = w_ref_acc && !w_ref_full;
    assign o_load_sym        = i_symbol;
    assign o_clr             = i_exit.lst;
    assign o_feed            = r_feed;
    assign o_feed_new        = r_feed_new;
    assign o_feed_old        = r_feed_old;
    assign o_valid           = r_valid;
    assign o_best_prefix_len = r_res_pfx;
    assign o_best_score      = r_res_score;
    assign o_length_overflow = r_res_ovf;

endmodule

`default_nettype wire

[hw/rtl/semi_global_overlap_alignment_unit.sv]
`default_nettype none
// Semi-global overlap scorer.
// Requests enter on start/busy: a request is taken at a clock edge with start high
// and busy low. i_opcode selects a reference symbol or a query symbol, i_is_last
// ends the query. Send the whole reference first, then the query.
// Reference symbols fill a chain of MAX_REF_LEN cells, one symbol per cell, one
// request per cycle. Each query symbol within MAX_QUERY_LEN launches one row of
// the score matrix down the chain; the row advances one cell per cycle, so query
// symbols are also taken one per cycle while earlier rows are still in flight.
// After the request with i_is_last, busy stays high until that row has left the
// chain: the result then appears on o_valid, held for exactly one cycle, and busy
// drops on the same edge. The receiver cannot stall the result. Emitting a result
// clears the reference, the scores and the overflow flag in the same cycle, so the
// next request starts a fresh job.
// Reset (i_rst_n low, synchronous) empties the chain and zeroes every cell's stored
// score at once; there is no clearing pass.
module semi_global_overlap_alignment_unit #(
    parameter int MAX_REF_LEN   = sgoa_pkg::DEF_MAX_REF_LEN,
    parameter int MAX_QUERY_LEN = sgoa_pkg::DEF_MAX_QUERY_LEN
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   i_opcode,
    input  wire logic [sgoa_pkg::SYM_W-1:0]             i_symbol,
    input  wire logic                                   i_is_last,
    output logic                                        o_valid,
    output logic [sgoa_pkg::PFX_W-1:0]                  o_best_prefix_len,
    output logic signed [sgoa_pkg::SCORE_OUT_W-1:0]     o_best_score,
    output logic                                        o_length_overflow
);
    import sgoa_pkg::*;

    localparam int RBITS   = $clog2(MAX_REF_LEN + 1);
    localparam int QBITS   = $clog2(MAX_QUERY_LEN + 1);
    localparam int SCORE_W = ((RBITS > QBITS) ? RBITS : QBITS) + 2;

    t_wave                     w_wave [0:MAX_REF_LEN];
    logic signed [SCORE_W-1:0] w_new  [0:MAX_REF_LEN];
    logic signed [SCORE_W-1:0] w_old  [0:MAX_REF_LEN];
    logic                      w_act  [0:MAX_REF_LEN];
    logic                      w_load;
    logic [SYM_W-1:0]          w_load_sym;
    logic                      w_clr;

    assign w_act[0] = 1'b1;

    sgoa_ctrl #(
        .MAX_REF_LEN   (MAX_REF_LEN),
        .MAX_QUERY_LEN (MAX_QUERY_LEN),
        .SCORE_W       (SCORE_W)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_symbol          (i_symbol),
        .i_is_last         (i_is_last),
        .o_load            (w_load),
        .o_load_sym        (w_load_sym),
        .o_clr             (w_clr),
        .o_feed            (w_wave[0]),
        .o_feed_new        (w_new[0]),
        .o_feed_old        (w_old[0]),
        .i_exit            (w_wave[MAX_REF_LEN]),
        .i_exit_new        (w_new[MAX_REF_LEN]),
        .o_valid           (o_valid),
        .o_best_prefix_len (o_best_prefix_len),
        .o_best_score      (o_best_score),
        .o_length_overflow (o_length_overflow)
    );

    for (genvar k = 0; k < MAX_REF_LEN; k++) begin : g_cell
        sgoa_cell #(
            .SCORE_W (SCORE_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clr      (w_clr),
            .i_load     (w_load),
            .i_load_sym (w_load_sym),
            .i_prev_act (w_act[k]),
            .o_act      (w_act[k+1]),
            .i_wave     (w_wave[k]),
            .i_new      (w_new[k]),
            .i_old      (w_old[k]),
            .o_wave     (w_wave[k+1]),
            .o_new      (w_new[k+1]),
            .o_old      (w_old[k+1])
        );
    end

endmodule

`default_nettype wire

[tb/semi_global_overlap_alignment_unit_tb.sv]
`timescale 1ns / 100ps

module semi_global_overlap_alignment_unit_tb;
    import sgoa_pkg::*;

    localparam int MAX_REF        = DEF_MAX_REF_LEN;
    localparam int MAX_QRY        = DEF_MAX_QUERY_LEN;
    localparam int RESULT_LATENCY = MAX_REF + 2;
    localparam int STALL_LIMIT    = 10 * RESULT_LATENCY;

    typedef struct packed {
        logic [PFX_W-1:0]              prefix_len;
        logic signed [SCORE_OUT_W-1:0] score;
        logic                          overflow;
    } t_overlap_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_opcode;
    logic [SYM_W-1:0]              i_symbol;
    logic                          i_is_last;
    logic                          o_valid;
    logic [PFX_W-1:0]              o_best_prefix_len;
    logic signed [SCORE_OUT_W-1:0] o_best_score;
    logic                          o_length_overflow;

    semi_global_overlap_alignment_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_symbol          (i_symbol),
        .i_is_last         (i_is_last),
        .o_valid           (o_valid),
        .o_best_prefix_len (o_best_prefix_len),
        .o_best_score      (o_best_score),
        .o_length_overflow (o_length_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // scorer state mirrored from the block's behavior
    logic [SYM_W-1:0] ref_syms [0:MAX_REF-1];
    int               row_score [0:MAX_REF];
    int unsigned      ref_len;
    int unsigned      qry_idx;
    int unsigned      kept_prefix;
    int               kept_score;
    bit               overflow_seen;

    t_overlap_result  overlap_expect_q [$];
    int               err_count;
    int               stall_cycles;
    int               send_idle_pct;
    int               items_sent;
    int               results_due;

    logic [SYM_W-1:0] job_alphabet [4];
    bit               job_wide;

    function automatic void clear_overlap_state();
        ref_len       = 0;
        qry_idx       = 0;
        kept_prefix   = 0;
        kept_score    = 0;
        overflow_seen = 1'b0;
        for (int j = 0; j <= MAX_REF; j++)
            row_score[j] = 0;
    endfunction

    function automatic void score_request(logic op, logic [SYM_W-1:0] sym, logic last);
        int diag;
        int up;
        int v;
        int row;
        int end_score;
        t_overlap_result res;
        if (op == OP_REF) begin
            if (qry_idx != 0)
                return;
            if (ref_len >= MAX_REF) begin
                overflow_seen = 1'b1;
                return;
            end
            ref_syms[ref_len] = sym;
            ref_len++;
            return;
        end
        if (qry_idx >= MAX_QRY) begin
            overflow_seen = 1'b1;
        end else begin
            qry_idx++;
            row = int'(qry_idx);
            diag = row_score[0];
            row_score[0] = -row;
            for (int j = 1; j <= int'(ref_len); j++) begin
                up = row_score[j];
                v = up - 1;
                if (row_score[j-1] - 1 > v)
                    v = row_score[j-1] - 1;
                if (diag - 1 > v)
                    v = diag - 1;
                if (ref_syms[j-1] == sym && diag + 1 > v)
                    v = diag + 1;
                diag = up;
                row_score[j] = v;
            end
            end_score = row_score[ref_len];
            if (end_score >= row / 2 && kept_score < end_score) begin
                kept_score  = end_score;
                kept_prefix = qry_idx;
            end
        end
        if (last) begin
            res.prefix_len = kept_prefix[PFX_W-1:0];
            res.score      = kept_score[SCORE_OUT_W-1:0];
            res.overflow   = overflow_seen;
            overlap_expect_q = {overlap_expect_q, res};
            results_due++;
            clear_overlap_state();
        end
    endfunction

    task automatic send_request(input logic op, input logic [SYM_W-1:0] sym,
                                input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_opcode  <= op;
        i_symbol  <= sym;
        i_is_last <= last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        score_request(op, sym, last);
    endtask

    function automatic logic [SYM_W-1:0] draw_symbol();
        if (job_wide)
            return SYM_W'($urandom_range(255));
        return job_alphabet[$urandom_range(3)];
    endfunction

    task automatic test_empty_reference();
        send_request(OP_QRY, 8'h00, 1'b0);
        send_request(OP_QRY, 8'hFF, 1'b0);
        send_request(OP_QRY, 8'h5A, 1'b1);
    endtask

    // extreme symbols, is_last on a reference character has no effect
    task automatic test_symbol_extremes();
        send_request(OP_REF, 8'h00, 1'b0);
        send_request(OP_REF, 8'hFF, 1'b1);
        send_request(OP_REF, 8'h00, 1'b1);
        send_request(OP_REF, 8'hFF, 1'b0);
        send_request(OP_QRY, 8'hFF, 1'b0);
        send_request(OP_QRY, 8'h00, 1'b0);
        send_request(OP_QRY, 8'hFF, 1'b1);
    endtask

    // reference characters once the query has begun are dropped
    task automatic test_late_reference();
        send_request(OP_REF, 8'h41, 1'b0);
        send_request(OP_REF, 8'h42, 1'b0);
        send_request(OP_QRY, 8'h41, 1'b0);
        send_request(OP_REF, 8'h43, 1'b1);
        send_request(OP_REF, 8'h42, 1'b0);
        send_request(OP_QRY, 8'h42, 1'b1);
    endtask

    // equal scores later in the query must not replace the first one
    task automatic test_first_best_kept();
        send_request(OP_REF, 8'h61, 1'b0);
        send_request(OP_REF, 8'h62, 1'b0);
        send_request(OP_QRY, 8'h62, 1'b0);
        send_request(OP_QRY, 8'h61, 1'b0);
        send_request(OP_QRY, 8'h62, 1'b0);
        send_request(OP_QRY, 8'h7F, 1'b1);
    endtask

    task automatic run_overlap_job();
        logic [SYM_W-1:0] ref_copy [$];
        logic [SYM_W-1:0] sym;
        int rlen;
        int qlen;
        int start_pos;
        job_wide = ($urandom_range(3) == 0);
        foreach (job_alphabet[k])
            job_alphabet[k] = SYM_W'($urandom_range(255));
        rlen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
        for (int k = 0; k < rlen; k++) begin
            sym = draw_symbol();
            ref_copy = {ref_copy, sym};
            send_request(OP_REF, sym, 1'(($urandom_range(3) == 0)));
        end
        qlen = $urandom_range(1, 12);
        // overlap the query with a reference suffix, mostly
        start_pos = rlen - $urandom_range((rlen < qlen) ? rlen : qlen);
        if ($urandom_range(7) == 0)
            start_pos = rlen;
        for (int k = 0; k < qlen; k++) begin
            if (k > 0 && $urandom_range(11) == 0)
                send_request(OP_REF, draw_symbol(), 1'($urandom_range(1)));
            if (start_pos + k < rlen && $urandom_range(9) > 1)
                sym = ref_copy[start_pos + k];
            else
                sym = draw_symbol();
            send_request(OP_QRY, sym, k == qlen - 1);
        end
        items_sent += rlen + qlen;
    endtask

    task automatic test_random_phase(input int idle_pct);
        int item_base;
        int result_base;
        send_idle_pct = idle_pct;
        item_base     = items_sent;
        result_base   = results_due;
        while (items_sent - item_base < 200 || results_due - result_base < 15)
            run_overlap_job();
    endtask

    always @(posedge i_clk) begin : result_check
        t_overlap_result want;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (o_valid) begin
                if (overlap_expect_q.size() == 0) begin
                    $error("unexpected result: best_prefix_len %0d best_score %0d",
                           o_best_prefix_len, o_best_score);
                    err_count++;
                end else begin
                    want = overlap_expect_q.pop_front();
                    if (o_best_prefix_len !== want.prefix_len) begin
                        $error("best_prefix_len: expected %0d, got %0d",
                               want.prefix_len, o_best_prefix_len);
                        err_count++;
                    end
                    if (o_best_score !== want.score) begin
                        $error("best_score: expected %0d, got %0d",
                               want.score, o_best_score);
                        err_count++;
                    end
                    if (o_length_overflow !== want.overflow) begin
                        $error("length_overflow: expected %0d, got %0d",
                               want.overflow, o_length_overflow);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_REF;
        i_symbol      = '0;
        i_is_last     = 1'b0;
        err_count     = 0;
        stall_cycles  = 0;
        items_sent    = 0;
        results_due   = 0;
        send_idle_pct = 13;
        clear_overlap_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_reference();
        test_symbol_extremes();
        test_late_reference();
        test_first_best_kept();
        test_random_phase(13);
        test_random_phase(48);
        test_random_phase(0);

        @(negedge i_clk);
        start <= 1'b0;
        while (overlap_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
